// ===== rtl/swlv_pkg.sv =====
// Shared constants, types and log tables of the sliding-window log variance block.
package swlv_pkg;

  localparam int MAX_DIMS   = 16;
  localparam int DIM_W      = $clog2(MAX_DIMS);
  localparam int DCFG_W     = 5;
  localparam int NFRAMES    = 7;
  localparam int SLOT_W     = $clog2(NFRAMES);
  localparam int CENTER_AGE = 3;
  localparam int NWIN       = 3;
  localparam int COEF_W     = 16;
  localparam int SQ_W       = 2 * COEF_W - 1;
  localparam int SX_W       = COEF_W + 3;
  localparam int SXX_W      = SQ_W + 3;
  localparam int NUM_W      = 36;
  localparam int E_W        = $clog2(NUM_W);
  localparam int LOG_TABLE_BITS = 8;
  localparam int LUT_SIZE   = 1 << LOG_TABLE_BITS;
  localparam int L2_W       = 24;
  localparam int PROD_W     = 41;
  localparam int LN_W       = PROD_W - 16;
  localparam int ACC_W      = 32;
  localparam int FRAME_W    = 16;
  localparam int OUT_W      = 216;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  typedef logic [15:0] lut_t [LUT_SIZE];
  typedef logic [L2_W-1:0] off_t [NWIN];

  // Per-item control that travels down the pipeline beside the data.
  typedef struct packed {
    logic [DIM_W-1:0]   d;
    logic [SLOT_W-1:0]  slot;
    logic               last;
    logic               emit;
    logic               clear;
    logic [DIM_W-1:0]   dsel;
    logic [FRAME_W-1:0] center;
  } ctl_t;

  // One log2 table entry, built by repeated squaring of a Q1.30 mantissa.
  function automatic logic [15:0] log_entry(int i);
    longint unsigned m;
    logic [15:0] r;
    m = longint'(LUT_SIZE + i) << (30 - LOG_TABLE_BITS);
    r = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= 64'h8000_0000) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  function automatic lut_t build_lut();
    lut_t t;
    for (int i = 0; i < LUT_SIZE; i++) begin
      t[i] = log_entry(i);
    end
    return t;
  endfunction

  // log2 in Q16.16 of a small constant, the same way the datapath does it.
  function automatic int log2_const(int v);
    int e;
    int idx;
    e = 0;
    for (int b = 0; b < 31; b++) begin
      if ((v >> b) != 0) e = b;
    end
    if (e >= LOG_TABLE_BITS) idx = v >> (e - LOG_TABLE_BITS);
    else idx = v << (LOG_TABLE_BITS - e);
    idx = idx & (LUT_SIZE - 1);
    return e * 65536 + int'(log_entry(idx));
  endfunction

  localparam lut_t LOG_LUT = build_lut();

  // log2(n*n) plus the Q16 scale of the numerator, per window.
  localparam off_t LOG_OFFSET = '{
    L2_W'(log2_const(9) + 16 * 65536),
    L2_W'(log2_const(25) + 16 * 65536),
    L2_W'(log2_const(49) + 16 * 65536)
  };

endpackage

// ===== rtl/swlv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swlv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/swlv_log_unit.sv =====
// Pipelined natural log of the variances of the three windows, from their numerators.
module swlv_log_unit
  import swlv_pkg::*;
(
  input  logic                       clk,
  input  logic [4:0]                 ld,      // stage loads, lowest stage first
  input  logic [NWIN-1:0][NUM_W-1:0] num_in,
  output logic [NWIN-1:0][LN_W-1:0]  ln_out
);

  logic [NWIN-1:0][NUM_W-1:0]  num6;
  logic [NWIN-1:0][E_W-1:0]    e6;
  logic [NWIN-1:0][E_W-1:0]    e_comb;
  logic [NWIN-1:0][E_W-1:0]    e7;
  logic [NWIN-1:0][LOG_TABLE_BITS-1:0] idx7;
  logic [NWIN-1:0][NUM_W-1:0]  norm;
  logic [NWIN-1:0][L2_W-1:0]   l2v8;
  logic [NWIN-1:0][PROD_W-1:0] p9;
  logic [NWIN-1:0][PROD_W-1:0] mag;
  logic [NWIN-1:0][PROD_W-1:0] q;

  // Position of the top set bit.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      e_comb[w] = '0;
      for (int b = 0; b < NUM_W; b++) begin
        if (num_in[w][b]) e_comb[w] = E_W'(b);
      end
    end
  end

  // Bits below the top bit select the table entry.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      norm[w] = num6[w] << (E_W'(NUM_W - 1) - e6[w]);
    end
  end

  // Rounding of the scaled product, half away from zero.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      mag[w] = p9[w][PROD_W-1] ? (~p9[w] + PROD_W'(1)) : p9[w];
      q[w]   = (mag[w] + PROD_W'(32768)) >> 16;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NWIN; w++) begin
      if (ld[0]) begin
        num6[w] <= num_in[w];
        e6[w]   <= e_comb[w];
      end
      if (ld[1]) begin
        e7[w]   <= e6[w];
        idx7[w] <= norm[w][NUM_W-2 -: LOG_TABLE_BITS];
      end
      if (ld[2]) begin
        l2v8[w] <= L2_W'({e7[w], 16'h0000}) + L2_W'(LOG_LUT[idx7[w]]) - LOG_OFFSET[w];
      end
      if (ld[3]) begin
        p9[w] <= PROD_W'($signed(l2v8[w]) * $signed({1'b0, LN2_Q16}));
      end
      if (ld[4]) begin
        ln_out[w] <= p9[w][PROD_W-1] ? LN_W'(~q[w] + PROD_W'(1)) : LN_W'(q[w]);
      end
    end
  end

endmodule

// ===== rtl/sliding_window_log_variance.sv =====
// Top level: sliding-window log variance of a cepstral coefficient stream.
// The block takes one Q8.8 coefficient per cycle on the s_ side unless stalled,
// a frame being dims_in_use coefficients (0 acts as 1, above 16 as 16). Once
// seven frames of an utterance are stored, each completed frame gives one
// result beat on the m_ side for the frame three back: the summed natural log
// of the per-dimension variance over 3, 5 and 7 frame windows, Q16.16, each
// with its change from the previous result. Each coefficient's share of the
// result is worked out as it arrives, in a ten-stage pipeline that accepts a
// new coefficient every cycle unless the m_ side stalls. The seven stored
// frames sit in seven small RAM banks, one per frame slot, all read at the
// incoming coefficient's dimension. Write dims_in_use only while idle.
module sliding_window_log_variance
  import swlv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DCFG_W-1:0] cfg_data,    // dims_in_use
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,     // coefficient
  input  logic              s_tuser,     // utterance_start
  output logic              m_tvalid,
  input  logic              m_tready,
  // center_frame, logdet_narrow, delta_narrow, logdet_middle, delta_middle,
  // logdet_wide, delta_wide, zero_variance, zero fill
  output logic [OUT_W-1:0]  m_tdata
);

  logic [DCFG_W-1:0]  dims_in_use;
  logic [DIM_W-1:0]   dim_count;
  logic [SLOT_W-1:0]  write_slot;
  logic [FRAME_W-1:0] frame_count;

  logic [10:1] v;
  logic [10:1] r;
  logic        go;
  logic        accept;
  ctl_t        ctl0;
  ctl_t        ctl [10:1];

  logic [DCFG_W-1:0]  dims_eff;
  logic [DIM_W-1:0]   d0;
  logic [SLOT_W-1:0]  slot0;
  logic [FRAME_W-1:0] fc0;
  logic               last0;

  logic [COEF_W-1:0]              bank_q [NFRAMES];
  logic [COEF_W-1:0]              sample1;
  logic [COEF_W-1:0]              x2   [NFRAMES];
  logic [SQ_W-1:0]                sq2  [NFRAMES];
  logic [SX_W-1:0]                sx_c  [NWIN];
  logic [SXX_W-1:0]               sxx_c [NWIN];
  logic [SX_W-1:0]                sx3  [NWIN];
  logic [SXX_W-1:0]               sxx3 [NWIN];
  logic [NUM_W-1:0]               nsxx4 [NWIN];
  logic [NUM_W-1:0]               sx2_4 [NWIN];
  logic [NWIN-1:0][NUM_W-1:0]     num5;
  logic [NUM_W:0]                 diff [NWIN];
  logic [NWIN-1:0]                zf [10:5];
  logic [NWIN-1:0][LN_W-1:0]      ln10;

  logic [NWIN-1:0][ACC_W-1:0] acc;
  logic [NWIN-1:0][ACC_W-1:0] acc_new;
  logic [NWIN-1:0]            zf_acc;
  logic [NWIN-1:0]            zf_new;
  logic [NWIN-1:0][ACC_W-1:0] pre_acc [MAX_DIMS];
  logic [NWIN-1:0]            pre_zf  [MAX_DIMS];
  logic [NWIN-1:0][ACC_W-1:0] fin;
  logic [NWIN-1:0]            fin_zf;
  logic [NWIN-1:0][ACC_W-1:0] prev;
  logic [NWIN-1:0][ACC_W-1:0] prev_eff;
  logic [NWIN-1:0][ACC_W-1:0] delta;
  logic [ACC_W:0]             dsum [NWIN];

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DCFG_W'(13);
    end else if (cfg_valid) begin
      dims_in_use <= cfg_data;
    end
  end

  // Pipeline flow: a stage loads when it is empty or its item moves on.
  always_comb begin
    go = v[10] && (!ctl[10].emit || !m_tvalid || m_tready);
    r[10] = !v[10] || go;
    for (int i = 9; i >= 1; i--) begin
      r[i] = !v[i] || r[i+1];
    end
  end
  assign s_tready = r[1];
  assign accept   = s_tvalid && r[1];

  // Frame bookkeeping for the incoming beat.
  always_comb begin
    if (dims_in_use == '0) dims_eff = DCFG_W'(1);
    else if (dims_in_use > DCFG_W'(MAX_DIMS)) dims_eff = DCFG_W'(MAX_DIMS);
    else dims_eff = dims_in_use;
    d0    = s_tuser ? '0 : dim_count;
    slot0 = s_tuser ? '0 : write_slot;
    fc0   = s_tuser ? '0 : frame_count;
    last0 = (DCFG_W'(d0) + DCFG_W'(1)) >= dims_eff;
    ctl0.d      = d0;
    ctl0.slot   = slot0;
    ctl0.last   = last0;
    ctl0.emit   = last0 && (fc0 >= FRAME_W'(NFRAMES - 1));
    ctl0.clear  = s_tuser;
    ctl0.dsel   = DIM_W'(dims_eff - DCFG_W'(1));
    ctl0.center = fc0 - FRAME_W'(CENTER_AGE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count   <= '0;
      write_slot  <= '0;
      frame_count <= '0;
    end else if (accept) begin
      if (last0) begin
        dim_count   <= '0;
        write_slot  <= (slot0 == SLOT_W'(NFRAMES - 1)) ? '0 : slot0 + SLOT_W'(1);
        frame_count <= (fc0 == '1) ? fc0 : fc0 + FRAME_W'(1);
      end else begin
        dim_count   <= d0 + DIM_W'(1);
        write_slot  <= slot0;
        frame_count <= fc0;
      end
    end
  end

  // Valid bits and control pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (r[1]) v[1] <= s_tvalid;
      for (int i = 2; i <= 10; i++) begin
        if (r[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r[1]) ctl[1] <= ctl0;
    for (int i = 2; i <= 10; i++) begin
      if (r[i]) ctl[i] <= ctl[i-1];
    end
  end

  // Frame store: one bank per frame slot, indexed by dimension.
  for (genvar b = 0; b < NFRAMES; b++) begin : g_bank
    swlv_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_DIMS)
    ) u_bank (
      .clk  (clk),
      .we   (accept && (slot0 == SLOT_W'(b))),
      .waddr(d0),
      .wdata(s_tdata),
      .re   (r[1]),
      .raddr(d0),
      .rdata(bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (r[1]) sample1 <= s_tdata;
  end

  // Stage 2: line the samples up by age and square them.
  always_ff @(posedge clk) begin
    logic [SLOT_W:0] s;
    logic [COEF_W-1:0] x;
    if (r[2]) begin
      for (int a = 0; a < NFRAMES; a++) begin
        s = {1'b0, ctl[1].slot} + (SLOT_W+1)'(NFRAMES - a);
        if (s >= (SLOT_W+1)'(NFRAMES)) s = s - (SLOT_W+1)'(NFRAMES);
        x = (a == 0) ? sample1 : bank_q[s[SLOT_W-1:0]];
        x2[a]  <= x;
        sq2[a] <= SQ_W'($signed(x) * $signed(x));
      end
    end
  end

  // Stage 3: window sums of x and x squared.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      sx_c[w]  = '0;
      sxx_c[w] = '0;
      for (int a = 0; a < NFRAMES; a++) begin
        if (a >= CENTER_AGE - (w + 1) && a <= CENTER_AGE + (w + 1)) begin
          sx_c[w]  = sx_c[w] + SX_W'($signed(x2[a]));
          sxx_c[w] = sxx_c[w] + SXX_W'(sq2[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r[3]) begin
      sx3  <= sx_c;
      sxx3 <= sxx_c;
    end
  end

  // Stage 4: n*Sxx and Sx squared.
  always_ff @(posedge clk) begin
    if (r[4]) begin
      for (int w = 0; w < NWIN; w++) begin
        nsxx4[w] <= NUM_W'(sxx3[w]) * NUM_W'(2 * w + 3);
        sx2_4[w] <= NUM_W'($signed(sx3[w]) * $signed(sx3[w]));
      end
    end
  end

  // Stage 5: variance numerator; zero or below is taken as the smallest step.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      diff[w] = {1'b0, nsxx4[w]} - {1'b0, sx2_4[w]};
    end
  end

  always_ff @(posedge clk) begin
    if (r[5]) begin
      for (int w = 0; w < NWIN; w++) begin
        if (diff[w][NUM_W] || diff[w] == '0) begin
          num5[w]  <= NUM_W'(1);
          zf[5][w] <= 1'b1;
        end else begin
          num5[w]  <= diff[w][NUM_W-1:0];
          zf[5][w] <= 1'b0;
        end
      end
    end
    for (int i = 6; i <= 10; i++) begin
      if (r[i]) zf[i] <= zf[i-1];
    end
  end

  // Stages 6 to 10: log of the numerators.
  swlv_log_unit u_log (
    .clk   (clk),
    .ld    (r[10:6]),
    .num_in(num5),
    .ln_out(ln10)
  );

  // Accumulate over dimensions; keep a prefix per dimension for short frames.
  always_comb begin
    for (int w = 0; w < NWIN; w++) begin
      acc_new[w] = ((ctl[10].d == '0) ? '0 : acc[w]) + ACC_W'($signed(ln10[w]));
      zf_new[w]  = ((ctl[10].d == '0) ? 1'b0 : zf_acc[w]) | zf[10][w];
      fin[w]     = (ctl[10].dsel == ctl[10].d) ? acc_new[w] : pre_acc[ctl[10].dsel][w];
      fin_zf[w]  = (ctl[10].dsel == ctl[10].d) ? zf_new[w] : pre_zf[ctl[10].dsel][w];
      prev_eff[w] = ctl[10].clear ? '0 : prev[w];
      dsum[w]    = {fin[w][ACC_W-1], fin[w]} - {prev_eff[w][ACC_W-1], prev_eff[w]};
      if (dsum[w][ACC_W] != dsum[w][ACC_W-1]) begin
        delta[w] = dsum[w][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        delta[w] = dsum[w][ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc    <= acc_new;
      zf_acc <= zf_new;
      pre_acc[ctl[10].d] <= acc_new;
      pre_zf[ctl[10].d]  <= zf_new;
    end
  end

  // Previous sums and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (go && ctl[10].emit) begin
        prev     <= fin;
        m_tvalid <= 1'b1;
      end else begin
        if (go && ctl[10].clear) prev <= '0;
        if (m_tready) m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl[10].emit) begin
      m_tdata <= {5'b0, fin_zf, delta[2], fin[2], delta[1], fin[1], delta[0], fin[0],
                  ctl[10].center};
    end
  end

  // Checks.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(NFRAMES - 1))
    else $error("write slot out of range");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    go && ctl[10].emit |=> m_tvalid && m_tdata[FRAME_W-1:0] == $past(ctl[10].center))
    else $error("emitted result not presented");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v[1])
    else $error("accepted beat lost at stage one");

  a_frame_sat: assert property (@(posedge clk) disable iff (rst)
    frame_count == '1 && !(accept && s_tuser) |=> frame_count == '1)
    else $error("frame count left saturation");

endmodule
